// ----- hdl/twcp_pkg.sv -----
// Package with the word types, constants and helper functions of the wall column pixel block.
`timescale 1ns / 1ps
`default_nettype none
package twcp_pkg;

  localparam int unsigned TexSize  = 64;
  localparam int unsigned TexCount = 8;

  localparam logic [9:0]  ScreenHeightReset = 10'd480;
  localparam logic [23:0] NearLimit         = 24'd7;
  localparam logic [15:0] HalfFrac          = 16'd32768;

  // Slice height quotient: (H << 16) / D, at most 26 bits.
  localparam int unsigned QuotW = 26;

  localparam logic OpDraw  = 1'b0;
  localparam logic OpWrite = 1'b1;

  localparam logic [0:0] RegScreenHeight = 1'd0;

  typedef struct packed {
    logic        operation;
    logic [10:0] column;
    logic [9:0]  row;
    logic [9:0]  horizon;
    logic [23:0] perp_distance;
    logic [15:0] hit_fraction;
    logic        face_side;
    logic [2:0]  tile;
    logic [11:0] texel_index;
    logic [31:0] texel_value;
  } in_word_t;

  typedef struct packed {
    logic        drawn;
    logic [10:0] out_column;
    logic [9:0]  out_row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
  } out_word_t;

  // Channel scaled by 7/10: (c*45878) >> 16 equals floor(c*7/10) for every 8-bit c,
  // since the excess over 7/10 stays below 0.011 and the fraction of c*7/10 is at most 0.9.
  function automatic logic [7:0] darken(input logic [7:0] c);
    logic [25:0] p;
    p = {18'd0, c} * 26'd45878;
    return p[23:16];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/textured_wall_column_pixel.sv -----
// Top level: slice height and texture row dividers, texture memory and shading.
// Pipeline: a 34-stage height divider, a 38-stage row divider, the registered
// memory read and the output register.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the output is stalled and full. Texel writes reach the memory at the
// stage where draws read it, so every draw sees the writes accepted before it.
// Reset clears the pipeline valid bits and sets screen_height to 480; the texture
// memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module textured_wall_column_pixel #(
  parameter int unsigned TexSizeP  = twcp_pkg::TexSize,
  parameter int unsigned TexCountP = twcp_pkg::TexCount
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [1:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire twcp_pkg::in_word_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output twcp_pkg::out_word_t     out_data_o
);
  import twcp_pkg::*;

  localparam int unsigned TsW    = $clog2(TexSizeP);
  localparam int unsigned SlotW  = (TexCountP > 1) ? $clog2(TexCountP) : 1;
  localparam int unsigned Depth  = TexCountP * TexSizeP * TexSizeP;
  localparam int unsigned AddrW  = $clog2(Depth);
  // Row dividend d*TexSize: d stays below 2^32 inside the slice.
  localparam int unsigned NumW   = 32 + TsW;
  localparam int unsigned DistW  = 24;

  // ---------------- configuration ----------------
  logic [9:0] screen_height_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_height_q <= ScreenHeightReset;
    end else if (psel && penable && pwrite && paddr[1:1] == RegScreenHeight) begin
      screen_height_q <= pwdata[9:0];
    end
  end
  assign prdata = (paddr[1:1] == RegScreenHeight) ? {22'd0, screen_height_q} : 32'd0;

  // ---------------- pipeline enable ----------------
  logic out_valid_q;
  logic en;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;
  logic acc;
  assign acc = in_valid_i && en;

  // ---------------- stage 1: height division ----------------
  logic wr_ok;
  assign wr_ok = in_data_i.operation == OpWrite
                 && {29'd0, in_data_i.tile} < TexCountP
                 && {20'd0, in_data_i.texel_index} < TexSizeP * TexSizeP;

  typedef struct packed {
    logic                operation;
    logic                write_en;
    logic [9:0]          sh;
    logic [10:0]         column;
    logic [9:0]          row;
    logic [9:0]          horizon;
    logic [15:0]         hit_fraction;
    logic                face_side;
    logic [2:0]          tile;
    logic [11:0]         texel_index;
    logic [31:0]         texel_value;
  } tag1_t;

  tag1_t t1_in, t1_out;
  logic h_valid;
  logic [DistW+9:0] h_quot;  // (sh<<16)/D, up to 26 significant bits
  assign t1_in = '{operation: in_data_i.operation, write_en: wr_ok,
                   sh: screen_height_q, column: in_data_i.column, row: in_data_i.row,
                   horizon: in_data_i.horizon, hit_fraction: in_data_i.hit_fraction,
                   face_side: in_data_i.face_side, tile: in_data_i.tile,
                   texel_index: in_data_i.texel_index,
                   texel_value: in_data_i.texel_value};

  // A near distance uses divisor 65536 so the quotient equals screen_height.
  logic [DistW+1:0] hden;
  assign hden = (in_data_i.perp_distance < NearLimit) ? 26'd65536
                                                      : {2'b00, in_data_i.perp_distance};

  twcp_div #(.NumW(DistW+10), .DenW(DistW+2), .TagW($bits(tag1_t))) u_hdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(acc),
    .num_i({8'd0, screen_height_q, 16'd0}), .den_i(hden), .tag_i(t1_in),
    .valid_o(h_valid), .quot_o(h_quot), .tag_o(t1_out)
  );

  // ---------------- stage 2: slice test and row division ----------------
  logic [QuotW-1:0] lh;
  assign lh = h_quot[QuotW-1:0];
  logic signed [27:0] ys, hz, half, dy;
  assign ys   = 28'(t1_out.row);
  assign hz   = 28'(t1_out.horizon);
  assign half = 28'(lh[QuotW-1:1]);
  assign dy   = ys - hz;
  logic in_slice;
  assign in_slice = t1_out.operation == OpDraw && (dy >= -half) && (dy < half)
                    && (t1_out.row < t1_out.sh);

  // d = dy*256 + lh*128, non-negative inside; numerator d*TexSize.
  logic signed [35:0] dval;
  assign dval = 36'(dy) * 36'sd256 + 36'(lh) * 36'sd128;
  logic [NumW-1:0] rnum;
  assign rnum = in_slice ? NumW'(dval[31:0]) * NumW'(TexSizeP) : '0;

  logic [TsW:0] tc_raw;
  logic         mirror;
  logic [TsW-1:0] tc;
  assign tc_raw = (TsW+1)'(({16'd0, t1_out.hit_fraction} * TexSizeP) >> 16);
  assign mirror = (!t1_out.face_side && t1_out.hit_fraction > HalfFrac)
               || (t1_out.face_side && t1_out.hit_fraction < HalfFrac);
  assign tc = mirror ? TsW'(TexSizeP - 1 - tc_raw) : TsW'(tc_raw);

  typedef struct packed {
    logic           drawn;
    logic           slot_ok;
    logic [SlotW-1:0] slot;
    logic [TsW-1:0] tc;
    logic [10:0]    column;
    logic [9:0]     row;
    logic           face_side;
    logic           write_en;
    logic [11:0]    texel_index;
    logic [31:0]    texel_value;
  } tag2_t;
  tag2_t t2_in, t2_out;
  assign t2_in = '{drawn: in_slice, slot_ok: {29'd0, t1_out.tile} < TexCountP,
                   slot: SlotW'(t1_out.tile), tc: tc, column: t1_out.column,
                   row: t1_out.row, face_side: t1_out.face_side,
                   write_en: t1_out.write_en, texel_index: t1_out.texel_index,
                   texel_value: t1_out.texel_value};

  logic r_valid;
  logic [NumW-1:0] r_quot;
  twcp_div #(.NumW(NumW), .DenW(QuotW), .TagW($bits(tag2_t))) u_rdiv (
    .clk_i, .rst_ni, .en_i(en), .valid_i(h_valid),
    .num_i(rnum), .den_i(in_slice ? lh : QuotW'(1)), .tag_i(t2_in),
    .valid_o(r_valid), .quot_o(r_quot), .tag_o(t2_out)
  );

  // ---------------- stage 3: texel write and read ----------------
  logic [NumW-9:0] trw;
  logic [TsW-1:0]  tr;
  assign trw = r_quot[NumW-1:8];
  assign tr  = (trw >= (NumW-8)'(TexSizeP)) ? TsW'(TexSizeP - 1) : TsW'(trw);

  // Writes and reads share this stage, so the memory sees them in word order.
  logic                tex_we;
  logic [AddrW-1:0]    tex_waddr;
  assign tex_we    = en && r_valid && t2_out.write_en;
  assign tex_waddr = AddrW'(t2_out.slot * (TexSizeP * TexSizeP) + t2_out.texel_index);

  logic [AddrW-1:0] tex_raddr;
  assign tex_raddr = AddrW'(t2_out.slot * (TexSizeP * TexSizeP) + tr * TexSizeP + t2_out.tc);
  logic [31:0] texel;
  twcp_ram #(.Width(32), .Depth(Depth)) u_tex (
    .clk_i, .we_i(tex_we), .waddr_i(tex_waddr), .wdata_i(t2_out.texel_value),
    .re_i(en), .raddr_i(tex_raddr), .rdata_o(texel)
  );

  logic  m_valid_q;
  tag2_t m_tag_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= r_valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_tag_q <= t2_out;
    end
  end

  // ---------------- stage 4: shading and output register ----------------
  logic [31:0] tx;
  assign tx = m_tag_q.slot_ok ? texel : 32'd0;
  out_word_t res_d, out_q;
  always_comb begin
    res_d = '0;
    if (m_tag_q.drawn) begin
      res_d.drawn      = 1'b1;
      res_d.out_column = m_tag_q.column;
      res_d.out_row    = m_tag_q.row;
      res_d.red   = m_tag_q.face_side ? darken(tx[31:24]) : tx[31:24];
      res_d.green = m_tag_q.face_side ? darken(tx[23:16]) : tx[23:16];
      res_d.blue  = m_tag_q.face_side ? darken(tx[15:8])  : tx[15:8];
      res_d.alpha = tx[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= m_valid_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res_d;
    end
  end
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("result changed while stalled");
  a_undrawn_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.drawn |-> out_q == '0)
    else $error("undrawn result not zero");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i)
    else $error("input stalled without output stall");
`endif
endmodule
`default_nettype wire

// ----- hdl/twcp_ram.sv -----
// Generic single-port write, single-port read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module twcp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ----- hdl/twcp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a side-band tag.
`timescale 1ns / 1ps
`default_nettype none
module twcp_div #(
  parameter int unsigned NumW = 34,
  parameter int unsigned DenW = 26,
  parameter int unsigned TagW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  input  wire logic [TagW-1:0] tag_i,
  output logic                 valid_o,
  output logic      [NumW-1:0] quot_o,
  output logic      [TagW-1:0] tag_o
);
  logic [NumW:0]     valid_q;
  logic [NumW-1:0]   num_q [NumW+1];
  logic [DenW:0]     rem_q [NumW+1];
  logic [DenW-1:0]   den_q [NumW+1];
  logic [TagW-1:0]   tag_q [NumW+1];

  always_comb begin
    valid_q[0] = valid_i;
    num_q[0]   = num_i;
    rem_q[0]   = '0;
    den_q[0]   = den_i;
    tag_q[0]   = tag_i;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW+1:0] trial;
    logic [DenW+1:0] shifted;
    assign shifted = {rem_q[s], num_q[s][NumW-1]};
    assign trial   = shifted - {2'b00, den_q[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[s+1] <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s+1] <= den_q[s];
        tag_q[s+1] <= tag_q[s];
        if (!trial[DenW+1]) begin
          rem_q[s+1] <= trial[DenW:0];
          num_q[s+1] <= {num_q[s][NumW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= shifted[DenW:0];
          num_q[s+1] <= {num_q[s][NumW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = valid_q[NumW];
  assign quot_o  = num_q[NumW];
  assign tag_o   = tag_q[NumW];
endmodule
`default_nettype wire

// ----- verif/textured_wall_column_pixel_tb.sv -----
// Self-checking testbench for the textured wall column pixel block.
`timescale 1ns / 1ps
`default_nettype none
module textured_wall_column_pixel_tb;
  import twcp_pkg::*;

  localparam int unsigned TexWords = TexSize * TexSize;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned DrainCycles = 80;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i, in_stall_o;
  in_word_t in_data_i;
  logic out_valid_o, out_stall_i;
  out_word_t out_data_o;

  textured_wall_column_pixel i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  // Shadow of the block's state.
  logic [31:0] tex_shadow [TexCount * TexWords];
  bit tex_written [TexCount * TexWords];
  logic [9:0] shadow_height;

  out_word_t pixel_queue[$];
  int unsigned fail_count;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] shade(input logic [7:0] c, input logic side);
    return side ? 8'((int'(c) * 7) / 10) : c;
  endfunction

  // Computes the result word for one input word and updates the shadow memory.
  function automatic out_word_t predict_pixel(input in_word_t w);
    out_word_t r;
    longint lh, start_row, end_row, d, tr, tc;
    logic [31:0] texel;
    r = '0;
    texel = '0;
    if (w.operation == OpWrite) begin
      if (w.tile < TexCount && w.texel_index < TexWords) begin
        tex_shadow[w.tile * TexWords + w.texel_index] = w.texel_value;
        tex_written[w.tile * TexWords + w.texel_index] = 1'b1;
      end
      return r;
    end
    if (w.perp_distance < NearLimit) lh = shadow_height;
    else lh = (longint'(shadow_height) << 16) / longint'(w.perp_distance);
    start_row = longint'(w.horizon) - lh / 2;
    end_row = longint'(w.horizon) + lh / 2;
    if (longint'(w.row) < start_row || longint'(w.row) >= end_row ||
        w.row >= shadow_height) return r;
    tc = (longint'(w.hit_fraction) * TexSize) >> 16;
    if ((w.face_side == 1'b0 && w.hit_fraction > HalfFrac) ||
        (w.face_side == 1'b1 && w.hit_fraction < HalfFrac))
      tc = TexSize - tc - 1;
    if (tc < 0) tc = 0;
    if (tc >= TexSize) tc = TexSize - 1;
    tr = 0;
    if (lh != 0) begin
      d = (longint'(w.row) - longint'(w.horizon)) * 256 + lh * 128;
      if (d < 0) d = 0;
      tr = ((d * TexSize) / lh) / 256;
      if (tr >= TexSize) tr = TexSize - 1;
    end
    if (w.tile < TexCount) texel = tex_shadow[w.tile * TexWords + tr * TexSize + tc];
    r.drawn = 1'b1;
    r.out_column = w.column;
    r.out_row = w.row;
    r.red = shade(texel[31:24], w.face_side);
    r.green = shade(texel[23:16], w.face_side);
    r.blue = shade(texel[15:8], w.face_side);
    r.alpha = texel[7:0];
    return r;
  endfunction

  // Index of the texel that a draw word would read when it was never written, else -1.
  function automatic int unwritten_texel(input in_word_t w);
    longint lh, d, tr, tc;
    int idx;
    if (w.operation == OpWrite || w.tile >= TexCount) return -1;
    if (w.perp_distance < NearLimit) lh = shadow_height;
    else lh = (longint'(shadow_height) << 16) / longint'(w.perp_distance);
    if (longint'(w.row) < longint'(w.horizon) - lh / 2 ||
        longint'(w.row) >= longint'(w.horizon) + lh / 2 ||
        w.row >= shadow_height) return -1;
    tc = (longint'(w.hit_fraction) * TexSize) >> 16;
    if ((w.face_side == 1'b0 && w.hit_fraction > HalfFrac) ||
        (w.face_side == 1'b1 && w.hit_fraction < HalfFrac))
      tc = TexSize - tc - 1;
    if (tc < 0) tc = 0;
    if (tc >= TexSize) tc = TexSize - 1;
    tr = 0;
    if (lh != 0) begin
      d = (longint'(w.row) - longint'(w.horizon)) * 256 + lh * 128;
      if (d < 0) d = 0;
      tr = ((d * TexSize) / lh) / 256;
      if (tr >= TexSize) tr = TexSize - 1;
    end
    idx = int'(longint'(w.tile) * TexWords + tr * TexSize + tc);
    return tex_written[idx] ? -1 : idx;
  endfunction

  // Sends one word; inputs change on the falling edge. Valid stays high after the
  // word until the next send or a drain takes it down.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixel_queue.push_back(predict_pixel(w));
    @(negedge clk_i);
  endtask

  // Guarded send: a draw that would hit an unwritten texel gets that texel written first.
  task automatic send_safe(input in_word_t w);
    int idx;
    idx = unwritten_texel(w);
    if (idx >= 0)
      send_word(texel_write(3'(idx / TexWords), 12'(idx % TexWords), $urandom));
    send_word(w);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pixel_queue.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_height(input logic [9:0] h);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'(RegScreenHeight) << 2 >> 2; pwdata <= {22'd0, h};
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    shadow_height = h;
  endtask

  function automatic in_word_t texel_write(input logic [2:0] t, input logic [11:0] idx,
                                           input logic [31:0] val);
    in_word_t w;
    w = '0;
    w.operation = OpWrite; w.tile = t; w.texel_index = idx; w.texel_value = val;
    return w;
  endfunction

  function automatic in_word_t random_draw();
    in_word_t w;
    w = '0;
    w.operation = OpDraw;
    w.column = 11'($urandom);
    w.horizon = 10'($urandom_range(shadow_height));
    case ($urandom_range(3))
      0: w.perp_distance = 24'($urandom_range(6));
      1: w.perp_distance = 24'($urandom_range(1 << 20, 7));
      2: w.perp_distance = 24'($urandom);
      default: w.perp_distance = 24'($urandom_range(1 << 17, 1 << 15));
    endcase
    w.row = ($urandom_range(3) == 0) ? 10'($urandom) :
            10'(int'(w.horizon) + $urandom_range(60) - 30);
    // Mostly the edge columns, so texels get read again after they were written.
    case ($urandom_range(3))
      0: w.hit_fraction = 16'($urandom);
      1: w.hit_fraction = 16'($urandom_range(65535, 63488));
      default: w.hit_fraction = 16'($urandom_range(2047));
    endcase
    w.face_side = 1'($urandom);
    w.tile = ($urandom_range(3) == 0) ? 3'($urandom) : 3'd0;
    w.texel_index = 12'($urandom);
    w.texel_value = $urandom;
    return w;
  endfunction

  task automatic test_directed();
    in_word_t w;
    send_word(texel_write(3'd0, 12'd0, 32'hFFFF_FFFF));
    send_word(texel_write(3'd0, 12'd4095, 32'h8040_20A5));
    send_word(texel_write(3'd1, 12'd2080, 32'h0000_0000));
    send_word(texel_write(3'd7, 12'd4095, 32'h1234_5678));
    w = '0;
    // Too near: full screen height slice.
    w.row = 10'd0; w.horizon = 10'd240; w.perp_distance = 24'd0; w.column = 11'd2047;
    send_safe(w);
    w.perp_distance = 24'd6; w.row = 10'd479; w.face_side = 1'b1; w.hit_fraction = 16'd0;
    send_safe(w);
    w.perp_distance = 24'd7; w.row = 10'd240; w.hit_fraction = 16'hFFFF; w.face_side = 1'b0;
    send_safe(w);
    w.perp_distance = 24'hFFFFFF; send_safe(w);
    w.perp_distance = 24'h010000; w.hit_fraction = 16'd32768; w.face_side = 1'b1; send_safe(w);
    w.face_side = 1'b0; send_safe(w);
    w.row = 10'd1023; w.horizon = 10'd1023; w.perp_distance = 24'd0; send_safe(w);
    w.row = 10'd0; w.horizon = 10'd0; send_safe(w);
    w.horizon = 10'd240; w.row = 10'd300; w.tile = 3'd7; send_safe(w);
    w.tile = 3'd0; w.texel_index = 12'hFFF; w.texel_value = 32'hFFFF_FFFF; send_safe(w);
    w.tile = 3'd6; w.hit_fraction = 16'd1; w.face_side = 1'b1; send_safe(w);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned count);
    in_word_t w;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0)
        w = texel_write(3'($urandom), 12'($urandom), $urandom);
      else
        w = random_draw();
      send_safe(w);
    end
  endtask

  // Runs random words at one screen height, then waits for the pipeline to empty.
  task automatic test_height(input logic [9:0] h, input int unsigned count);
    write_height(h);
    test_random(count);
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; in_data_i = '0; out_stall_i = 1'b0;
    fail_count = 0;
    shadow_height = ScreenHeightReset;
    send_idle_pct = 0; recv_idle_pct = 0;
    foreach (tex_written[i]) tex_written[i] = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_idle_pct = 37; recv_idle_pct = 77;
    test_directed();
    test_height(10'd480, 300);
    test_height(10'd1, 100);
    send_idle_pct = 77; recv_idle_pct = 37;
    test_height(10'd1023, 300);
    test_height(10'd0, 50);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_height(10'd200, 400);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    out_word_t exp_word;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pixel_queue.size() == 0) begin
        $error("unexpected result word %h", out_data_o);
        fail_count++;
      end else begin
        exp_word = pixel_queue.pop_front();
        if (out_data_o.drawn !== exp_word.drawn) begin
          $error("drawn: expected %0d, got %0d", exp_word.drawn, out_data_o.drawn);
          fail_count++;
        end
        if (out_data_o.out_column !== exp_word.out_column) begin
          $error("out_column: expected %0d, got %0d", exp_word.out_column,
                 out_data_o.out_column);
          fail_count++;
        end
        if (out_data_o.out_row !== exp_word.out_row) begin
          $error("out_row: expected %0d, got %0d", exp_word.out_row, out_data_o.out_row);
          fail_count++;
        end
        if (out_data_o.red !== exp_word.red) begin
          $error("red: expected %0d, got %0d", exp_word.red, out_data_o.red);
          fail_count++;
        end
        if (out_data_o.green !== exp_word.green) begin
          $error("green: expected %0d, got %0d", exp_word.green, out_data_o.green);
          fail_count++;
        end
        if (out_data_o.blue !== exp_word.blue) begin
          $error("blue: expected %0d, got %0d", exp_word.blue, out_data_o.blue);
          fail_count++;
        end
        if (out_data_o.alpha !== exp_word.alpha) begin
          $error("alpha: expected %0d, got %0d", exp_word.alpha, out_data_o.alpha);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word while work is pending.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (pixel_queue.size() == 0 && !in_valid_i))
      idle_cycles <= 0;
    else if (idle_cycles >= WatchLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/twcp_pkg.sv
hdl/twcp_ram.sv
hdl/twcp_div.sv
hdl/textured_wall_column_pixel.sv
verif/textured_wall_column_pixel_tb.sv
